### hw/rtl/udpot_pkg.sv
// ----------------------------------------------------------------------------
// udpot_pkg
// Shared types and constants for the up/down potentiometer pulse sequencer.
// ----------------------------------------------------------------------------
package udpot_pkg;

    localparam int MAX_STEP = 99;

    localparam int POS_W  = 7;
    localparam int WAIT_W = 16;
    localparam int TICK_W = 4;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [POS_W-1:0]  CLEAR_PULSE_RST = 7'd99;
    localparam logic [TICK_W-1:0] SETTLE_RST      = 4'd3;
    localparam logic [TICK_W-1:0] HALF_RST        = 4'd1;
    localparam logic [WAIT_W-1:0] STORE_WAIT_RST  = 16'd20000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_STORE = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_CLEAR_PULSE = 2'd0,
        REG_SETTLE      = 2'd1,
        REG_HALF_PULSE  = 2'd2,
        REG_STORE_WAIT  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SEL     = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_HIGH    = 3'd3,
        PH_LOW     = 3'd4,
        PH_END     = 3'd5,
        PH_ST_INC  = 3'd6,
        PH_ST_WAIT = 3'd7
    } phase_t;

    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic inc_pin;
        logic up_dir;
        logic chip_select_n;
    } result_t;

endpackage

### hw/rtl/updown_pot_pulse_sequencer_top.sv
// ----------------------------------------------------------------------------
// updown_pot_pulse_sequencer_top
// Drives the three pins of an up/down digital potentiometer from a stream
// of one-microsecond ticks and set-position or store commands.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one transaction per tick or command. A set
// command selects the chip, clears the wiper with down pulses and then
// pulses up to the saturated target. A store command raises increment,
// deselects and stays busy for the programmed wait. Commands that arrive
// while a sequence runs are ignored and flagged as rejected.
// Every input transaction produces exactly one result transaction on the
// master channel with the pin levels after that item, registered in the
// cycle after it is accepted when the output register is free; otherwise
// it waits in the buffer until the result ahead of it is taken. One
// transaction is accepted per cycle while s_tready is high; the sequencer
// state and the result register are updated in that same cycle.
// A two-entry output buffer lets one more input be taken while a result
// waits; s_tready falls only when both entries are full.
// Reset returns the sequencer to idle with the chip deselected, increment
// high, direction down and the register defaults loaded. Configuration
// writes are taken at any edge with cfg_we high.
// ----------------------------------------------------------------------------
module updown_pot_pulse_sequencer_top
    import udpot_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // op[1:0], position[8:2], zeros
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // chip_select_n, up_dir, inc_pin,
                                         // busy_res, rejected, zeros
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [POS_W-1:0]  clear_pulse_reg;
    logic [TICK_W-1:0] settle_reg;
    logic [TICK_W-1:0] half_reg;
    logic [WAIT_W-1:0] store_wait_reg;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pulse_reg, pulse_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic              cs_reg, cs_next;
    logic              dir_reg, dir_next;
    logic              inc_reg, inc_next;

    logic              out_valid_reg, skid_valid_reg;
    result_t           out_data_reg, skid_data_reg;
    result_t           result;

    op_t               op;
    logic [POS_W-1:0]  position;
    logic              accept, pop, active;
    logic              tick_on, cmd_set, cmd_store, fire;
    logic [WAIT_W-1:0] wait_dec;
    logic [POS_W-1:0]  run_count, target_sat;

    assign op       = op_t'(s_tdata[1:0]);
    assign position = s_tdata[8:2];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign active   = (phase_reg != PH_IDLE);

    assign tick_on   = accept && (op == OP_TICK) && active;
    assign cmd_set   = accept && (op == OP_SET) && !active;
    assign cmd_store = accept && (op == OP_STORE) && !active;
    assign wait_dec  = (wait_reg != '0) ? wait_reg - 1'b1 : '0;
    assign fire      = tick_on && (wait_dec == '0);

    assign run_count  = (phase_reg == PH_SETTLE) ? (dir_reg ? target_reg : clear_pulse_reg)
                                                  : pulse_reg;
    assign target_sat = (position > POS_W'(MAX_STEP)) ? POS_W'(MAX_STEP) : position;

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd_set)
        begin
            phase_next = PH_SEL;
        end
        else if (cmd_store)
        begin
            phase_next = PH_ST_INC;
        end
        else if (fire)
        begin
            unique case (phase_reg) inside
                PH_SEL:
                begin
                    phase_next = PH_SETTLE;
                end
                PH_SETTLE, PH_LOW:
                begin
                    if (run_count != '0)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else if (!dir_reg)
                    begin
                        phase_next = PH_SETTLE;
                    end
                    else
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_HIGH:    phase_next = PH_LOW;
                PH_END:     phase_next = PH_IDLE;
                PH_ST_INC:  phase_next = PH_ST_WAIT;
                PH_ST_WAIT: phase_next = PH_IDLE;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        pulse_next  = pulse_reg;
        wait_next   = wait_reg;
        target_next = target_reg;
        cs_next     = cs_reg;
        dir_next    = dir_reg;
        inc_next    = inc_reg;
        if (tick_on)
        begin
            wait_next = wait_dec;
        end
        if (cmd_set)
        begin
            target_next = target_sat;
            cs_next     = 1'b0;
            wait_next   = WAIT_W'(1);
        end
        else if (cmd_store)
        begin
            inc_next  = 1'b1;
            wait_next = WAIT_W'(1);
        end
        else if (fire)
        begin
            unique case (phase_reg) inside
                PH_SEL:
                begin
                    dir_next  = 1'b0;
                    wait_next = WAIT_W'(settle_reg);
                end
                PH_SETTLE, PH_LOW:
                begin
                    pulse_next = run_count;
                    if (run_count != '0)
                    begin
                        inc_next  = 1'b1;
                        wait_next = WAIT_W'(half_reg);
                    end
                    else if (!dir_reg)
                    begin
                        dir_next  = 1'b1;
                        wait_next = WAIT_W'(settle_reg);
                    end
                    else
                    begin
                        inc_next  = 1'b0;
                        wait_next = WAIT_W'(1);
                    end
                end
                PH_HIGH:
                begin
                    inc_next   = 1'b0;
                    pulse_next = pulse_reg - 1'b1;
                    wait_next  = WAIT_W'(half_reg);
                end
                PH_END:
                begin
                    cs_next = 1'b1;
                end
                PH_ST_INC:
                begin
                    cs_next   = 1'b1;
                    wait_next = store_wait_reg;
                end
                default:
                begin
                    wait_next = wait_dec;
                end
            endcase
        end
    end

    always_comb
    begin
        result.chip_select_n = cs_next;
        result.up_dir        = dir_next;
        result.inc_pin       = inc_next;
        result.busy_res      = (phase_next != PH_IDLE);
        result.rejected      = accept && active && ((op == OP_SET) || (op == OP_STORE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pulse_reg <= CLEAR_PULSE_RST;
            settle_reg      <= SETTLE_RST;
            half_reg        <= HALF_RST;
            store_wait_reg  <= STORE_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CLEAR_PULSE: clear_pulse_reg <= cfg_data[POS_W-1:0];
                REG_SETTLE:      settle_reg      <= cfg_data[TICK_W-1:0];
                REG_HALF_PULSE:  half_reg        <= cfg_data[TICK_W-1:0];
                REG_STORE_WAIT:  store_wait_reg  <= cfg_data[WAIT_W-1:0];
                default:         clear_pulse_reg <= clear_pulse_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pulse_reg  <= '0;
            wait_reg   <= '0;
            target_reg <= '0;
            cs_reg     <= 1'b1;
            dir_reg    <= 1'b0;
            inc_reg    <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pulse_reg  <= pulse_next;
            wait_reg   <= wait_next;
            target_reg <= target_next;
            cs_reg     <= cs_next;
            dir_reg    <= dir_next;
            inc_reg    <= inc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule

### hw/rtl/udpot_checker.sv
// ----------------------------------------------------------------------------
// udpot_checker
// Port-level checks for the up/down potentiometer pulse sequencer.
// ----------------------------------------------------------------------------
module udpot_checker
    import udpot_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input only stalls when results are waiting.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // A refused command can only happen while a sequence is running.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("rejected without busy");

    // When no sequence runs the chip is deselected.
    a_idle_desel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[0])
        else $error("chip selected while idle");

    // After every accepted item some result is valid in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted item");

endmodule

bind updown_pot_pulse_sequencer_top udpot_checker u_udpot_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/updown_pot_pulse_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updown_pot_pulse_sequencer_top_tb
// Self-checking bench for the potentiometer pulse sequencer. A directed
// table exercises idle behavior, every command, saturation and rejection.
// Random tick and command streams then follow under several register
// settings and handshake idling patterns. A transaction model predicts the
// pin levels for every transaction, and each output transaction is compared
// field by field against the table's known levels or else those predictions.
// ----------------------------------------------------------------------------
module updown_pot_pulse_sequencer_top_tb;
    import udpot_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] pos;
        logic       known;
        result_t    res;
    } stim_row_t;

    localparam int NUM_DIRECTED = 22;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_CYCLES  = 64;

    // Known levels are rejected, busy_res, inc_pin, up_dir, chip_select_n.
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        {OP_TICK,  7'd0,   1'b1, 5'b00101},
        {OP_NOP,   7'd127, 1'b1, 5'b00101},
        {OP_STORE, 7'd127, 1'b1, 5'b01101},
        {OP_SET,   7'd50,  1'b1, 5'b11101},
        {OP_STORE, 7'd0,   1'b1, 5'b11101},
        {OP_TICK,  7'd85,  1'b1, 5'b01101},
        {OP_TICK,  7'd0,   1'b1, 5'b01101},
        {OP_TICK,  7'd0,   1'b1, 5'b00101},
        {OP_TICK,  7'd42,  1'b1, 5'b00101},
        {OP_SET,   7'd127, 1'b1, 5'b01100},
        {OP_STORE, 7'd0,   1'b1, 5'b11100},
        {OP_NOP,   7'd0,   1'b1, 5'b01100},
        {OP_TICK,  7'd0,   1'b1, 5'b01100},
        {OP_TICK,  7'd1,   1'b0, 5'b00000},
        {OP_TICK,  7'd2,   1'b0, 5'b00000},
        {OP_TICK,  7'd4,   1'b0, 5'b00000},
        {OP_TICK,  7'd8,   1'b0, 5'b00000},
        {OP_TICK,  7'd16,  1'b0, 5'b00000},
        {OP_TICK,  7'd32,  1'b0, 5'b00000},
        {OP_TICK,  7'd64,  1'b0, 5'b00000},
        {OP_TICK,  7'd127, 1'b0, 5'b00000},
        {OP_SET,   7'd99,  1'b1, 5'b11000}
    };

    localparam int PH_CLEAR  [NUM_PHASES] = '{0, 5, 2, 127, 3, 4};
    localparam int PH_SETTLE_T [NUM_PHASES] = '{0, 2, 15, 1, 0, 1};
    localparam int PH_HALF   [NUM_PHASES] = '{0, 1, 2, 15, 1, 3};
    localparam int PH_STORE  [NUM_PHASES] = '{0, 3, 10, 1, 0, 65535};
    localparam int PH_ITEMS  [NUM_PHASES] = '{150, 150, 150, 40, 150, 150};
    localparam idle_mode_t PH_MODE [NUM_PHASES] =
        '{IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH, IDLE_BOTH, IDLE_NONE};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_CLEAR_PULSE;
    logic [CFG_W-1:0] cfg_data = '0;

    idle_mode_t mode = IDLE_NONE;
    bit         hold_toggle = 1'b0;
    bit         hold_seen = 1'b0;
    int         hold_left = 0;
    int         fail_count = 0;
    result_t    pin_levels_due [$];

    logic [6:0]  clear_count = CLEAR_PULSE_RST;
    logic [3:0]  settle_ticks = SETTLE_RST;
    logic [3:0]  half_ticks = HALF_RST;
    logic [15:0] store_wait = STORE_WAIT_RST;

    phase_t      seq_ph = PH_IDLE;
    logic [6:0]  pulse_cnt = '0;
    logic [15:0] wait_cnt = '0;
    logic [6:0]  target = '0;
    logic        cs_lvl = 1'b1;
    logic        dir_lvl = 1'b0;
    logic        inc_lvl = 1'b1;

    updown_pot_pulse_sequencer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void load_pulse_run(logic [6:0] count);
        pulse_cnt = count;
        if (count == 7'd0)
        begin
            if (!dir_lvl)
            begin
                dir_lvl = 1'b1;
                wait_cnt = 16'(settle_ticks);
                seq_ph = PH_SETTLE;
            end
            else
            begin
                inc_lvl = 1'b0;
                wait_cnt = 16'd1;
                seq_ph = PH_END;
            end
        end
        else
        begin
            inc_lvl = 1'b1;
            wait_cnt = 16'(half_ticks);
            seq_ph = PH_HIGH;
        end
    endfunction

    function automatic result_t pin_levels_after(op_t op, logic [6:0] pos);
        result_t r;
        logic    rej;
        rej = 1'b0;
        if (op == OP_TICK)
        begin
            if (seq_ph != PH_IDLE)
            begin
                if (wait_cnt != 16'd0)
                    wait_cnt = wait_cnt - 16'd1;
                if (wait_cnt == 16'd0)
                begin
                    case (seq_ph)
                        PH_SEL:
                        begin
                            dir_lvl = 1'b0;
                            wait_cnt = 16'(settle_ticks);
                            seq_ph = PH_SETTLE;
                        end
                        PH_SETTLE:
                            load_pulse_run(dir_lvl ? target : clear_count);
                        PH_HIGH:
                        begin
                            inc_lvl = 1'b0;
                            pulse_cnt = pulse_cnt - 7'd1;
                            wait_cnt = 16'(half_ticks);
                            seq_ph = PH_LOW;
                        end
                        PH_LOW:
                            load_pulse_run(pulse_cnt);
                        PH_END:
                        begin
                            cs_lvl = 1'b1;
                            seq_ph = PH_IDLE;
                        end
                        PH_ST_INC:
                        begin
                            cs_lvl = 1'b1;
                            wait_cnt = store_wait;
                            seq_ph = PH_ST_WAIT;
                        end
                        default:
                            seq_ph = PH_IDLE;
                    endcase
                end
            end
        end
        else if (op == OP_SET || op == OP_STORE)
        begin
            if (seq_ph != PH_IDLE)
                rej = 1'b1;
            else if (op == OP_SET)
            begin
                target = (pos > MAX_STEP) ? 7'(MAX_STEP) : pos;
                cs_lvl = 1'b0;
                wait_cnt = 16'd1;
                seq_ph = PH_SEL;
            end
            else
            begin
                inc_lvl = 1'b1;
                wait_cnt = 16'd1;
                seq_ph = PH_ST_INC;
            end
        end
        r.chip_select_n = cs_lvl;
        r.up_dir        = dir_lvl;
        r.inc_pin       = inc_lvl;
        r.busy_res      = (seq_ph != PH_IDLE);
        r.rejected      = rej;
        return r;
    endfunction

    function automatic bit sender_gap();
        if (mode == IDLE_SRC)
            return $urandom_range(0, 99) < 73;
        if (mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 12;
        return 1'b0;
    endfunction

    task automatic push_item(op_t op, logic [6:0] pos, logic use_given, result_t given);
        result_t predicted;
        while (sender_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = pin_levels_after(op, pos);
        pin_levels_due.push_back(use_given ? given : predicted);
    endtask

    task automatic cfg_write(reg_idx_t idx, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        case (idx)
            REG_CLEAR_PULSE: clear_count  = 7'(value);
            REG_SETTLE:      settle_ticks = 4'(value);
            REG_HALF_PULSE:  half_ticks   = 4'(value);
            default:         store_wait   = 16'(value);
        endcase
    endtask

    task automatic drain_to_quiet();
        s_tvalid <= 1'b0;
        while (pin_levels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        string   names [5];
        names = '{"chip_select_n", "up_dir", "inc_pin", "busy_res", "rejected"};
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[4:0]);
            if (pin_levels_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got %b", $time, got);
                fail_count++;
            end
            else
            begin
                want = pin_levels_due.pop_front();
                for (int i = 0; i < 5; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: %s expected %b got %b", $time, names[i], want[i],
                                 got[i]);
                        fail_count++;
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (mode == IDLE_SINK)
            m_tready <= $urandom_range(0, 99) >= 73;
        else if (mode == IDLE_BOTH)
            m_tready <= $urandom_range(0, 99) >= 12;
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("updown_pot_pulse_sequencer_top regression: fail");
        $finish;
    end

    initial
    begin
        int         r;
        op_t        rop;
        logic [6:0] rpos;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_write(REG_STORE_WAIT, 2);
        cfg_we <= 1'b0;
        @(posedge clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            push_item(DIRECTED[k].op, DIRECTED[k].pos, DIRECTED[k].known, DIRECTED[k].res);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_to_quiet();
            cfg_write(REG_CLEAR_PULSE, PH_CLEAR[p]);
            cfg_write(REG_SETTLE, PH_SETTLE_T[p]);
            cfg_write(REG_HALF_PULSE, PH_HALF[p]);
            cfg_write(REG_STORE_WAIT, PH_STORE[p]);
            cfg_we <= 1'b0;
            mode = PH_MODE[p];
            if (PH_MODE[p] == IDLE_SINK)
                hold_toggle = ~hold_toggle;
            for (int n = 0; n < PH_ITEMS[p]; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 72)
                    rop = OP_TICK;
                else if (r < 84)
                    rop = OP_SET;
                else if (r < 92)
                    rop = OP_STORE;
                else
                    rop = OP_NOP;
                r = $urandom_range(0, 99);
                if (r < 55)
                    rpos = 7'($urandom_range(0, 6));
                else if (r < 80)
                    rpos = 7'($urandom_range(0, 127));
                else
                    rpos = 7'($urandom_range(95, 127));
                push_item(rop, rpos, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pin_levels_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("updown_pot_pulse_sequencer_top regression: pass");
        else
            $display("updown_pot_pulse_sequencer_top regression: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/udpot_pkg.sv
hw/rtl/updown_pot_pulse_sequencer_top.sv
hw/rtl/udpot_checker.sv
tb/sv/updown_pot_pulse_sequencer_top_tb.sv
